/* sv/pes_pkg.sv */
// ----------------------------------------------------------------------------
// Playlist event scheduler package
// Shared types and codes for the scheduler top level and its table cells.
// ----------------------------------------------------------------------------
package pes_pkg;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_FETCH = 1'b1;

    localparam logic [2:0] ST_ADDED     = 3'd0;
    localparam logic [2:0] ST_NO_TRANSP = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_GIVEN     = 3'd3;
    localparam logic [2:0] ST_NONE      = 3'd4;

    localparam logic [1:0] KIND_START    = 2'd0;
    localparam logic [1:0] KIND_STOP     = 2'd1;
    localparam logic [1:0] KIND_FADE_IN  = 2'd2;
    localparam logic [1:0] KIND_FADE_OUT = 2'd3;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] track;
    } t_ev_tag;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_CHECK = 9'b000000010,
        S_INS0  = 9'b000000100,
        S_INS1  = 9'b000001000,
        S_INS2  = 9'b000010000,
        S_INS3  = 9'b000100000,
        S_FETCH = 9'b001000000,
        S_FCMP  = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

endpackage

/* sv/playlist_event_scheduler_top.sv */
// ----------------------------------------------------------------------------
// Playlist event scheduler
// Time-sorted queue of track start, stop and fade events held in a cell row.
// ----------------------------------------------------------------------------
// An item on the input channel either adds a track's events or fetches the
// next event before a block end. Every item gives exactly one result item.
// An item is taken when i_valid is high and o_stall is low; a result is taken
// when o_valid is high and i_stall is low. o_stall stays high from the accept
// until the result is loaded into the output register.
// An add passes through a check state, then one insert state for each of its
// start, stop and fade events, since the cell row takes one insertion per
// cycle, and then a done state. A rejected add goes from the check state to
// the done state; a fetch registers the table read before the time compare.
// The next item can be taken once the result is in the output register.
// A stalled receiver holds the result in the output register; the next item
// may still be taken and worked on, and its result waits until the register
// frees up. Reset empties the table, clears the read pointer and the running
// sample sum, and drops any pending result.
// ----------------------------------------------------------------------------
module playlist_event_scheduler_top #(
    parameter int TABLE_DEPTH = 64,
    parameter int TIME_BITS   = 48
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_opcode,
    input  logic               i_has_transport,
    input  logic [7:0]         i_track_id,
    input  logic [31:0]        i_total_samples,
    input  logic [31:0]        i_overlap_samples,
    input  logic signed [32:0] i_remaining_samples,
    input  logic [31:0]        i_fade_in_samples,
    input  logic [31:0]        i_fade_out_samples,
    input  logic signed [47:0] i_block_end,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [2:0]         o_status,
    output logic signed [47:0] o_event_time,
    output logic [1:0]         o_event_kind,
    output logic [7:0]         o_event_track
);
    import pes_pkg::*;

    localparam int CW   = $clog2(TABLE_DEPTH + 1);
    localparam int IW   = $clog2(TABLE_DEPTH);
    localparam int CMPW = (TIME_BITS > 48) ? TIME_BITS : 48;
    localparam logic signed [TIME_BITS-1:0] TMAX = {1'b0, {(TIME_BITS-1){1'b1}}};
    localparam logic signed [TIME_BITS-1:0] TMIN = {1'b1, {(TIME_BITS-1){1'b0}}};

    function automatic logic signed [TIME_BITS-1:0] sat_add(
        input logic signed [TIME_BITS-1:0] a,
        input logic signed [TIME_BITS-1:0] b
    );
        logic signed [TIME_BITS:0] s;
        s = (TIME_BITS+1)'(a) + (TIME_BITS+1)'(b);
        if (s[TIME_BITS] != s[TIME_BITS-1]) begin
            return s[TIME_BITS] ? TMIN : TMAX;
        end
        return s[TIME_BITS-1:0];
    endfunction

    t_state r_state;

    logic               r_transport;
    logic [7:0]         r_track;
    logic [31:0]        r_total;
    logic [31:0]        r_overlap;
    logic signed [32:0] r_remain;
    logic               r_fin_nz;
    logic [31:0]        r_fout;
    logic signed [47:0] r_bend;

    logic signed [TIME_BITS-1:0] r_sum;
    logic signed [TIME_BITS-1:0] r_start;
    logic signed [TIME_BITS-1:0] r_stop;
    logic signed [TIME_BITS-1:0] r_fout_time;
    logic [CW-1:0]               r_count;
    logic [CW-1:0]               r_rd_idx;
    logic                        r_rd_ok;
    logic signed [TIME_BITS-1:0] r_rd_time;
    t_ev_tag                     r_rd_tag;

    logic [2:0]  r_res_status;
    logic [47:0] r_res_time;
    logic [1:0]  r_res_kind;
    logic [7:0]  r_res_track;

    logic        r_out_valid;
    logic [2:0]  r_out_status;
    logic [47:0] r_out_time;
    logic [1:0]  r_out_kind;
    logic [7:0]  r_out_track;

    logic                        w_accept;
    logic [2:0]                  w_n_events;
    logic                        w_full;
    logic signed [33:0]          w_tmo;
    logic signed [33:0]          w_neg_ovl;
    logic signed [33:0]          w_rmt;
    logic signed [33:0]          w_neg_fout;
    logic                        w_remain_pos;
    logic signed [TIME_BITS-1:0] w_start_calc;
    logic signed [TIME_BITS-1:0] w_sum_calc;
    logic signed [TIME_BITS-1:0] w_stop_calc;
    logic signed [TIME_BITS-1:0] w_fout_calc;
    logic signed [CMPW-1:0]      w_time_ext;
    logic signed [CMPW-1:0]      w_bend_ext;
    logic                        w_hit;

    logic                        w_ins_en;
    logic signed [TIME_BITS-1:0] w_ins_time;
    t_ev_tag                     w_ins_tag;

    logic signed [TIME_BITS-1:0] w_cell_time  [TABLE_DEPTH];
    t_ev_tag                     w_cell_tag   [TABLE_DEPTH];
    logic                        w_cell_shift [TABLE_DEPTH];

    assign o_stall  = (r_state != S_IDLE);
    assign w_accept = i_valid && !o_stall;

    assign w_n_events = 3'd2 + {2'b00, r_fin_nz} + {2'b00, (r_fout != 32'd0)};
    assign w_full     = ({1'b0, r_count} + (CW+1)'(w_n_events)) > (CW+1)'(TABLE_DEPTH);

    assign w_tmo        = $signed({2'b00, r_total}) - $signed({2'b00, r_overlap});
    assign w_neg_ovl    = 34'sd0 - $signed({2'b00, r_overlap});
    assign w_rmt        = $signed({r_remain[32], r_remain}) - $signed({2'b00, r_total});
    assign w_neg_fout   = 34'sd0 - $signed({2'b00, r_fout});
    assign w_remain_pos = !r_remain[32] && (r_remain != 33'sd0);

    assign w_start_calc = (r_sum[TIME_BITS-1] || (r_sum == '0)) ? '0
                        : sat_add(r_sum, TIME_BITS'(w_neg_ovl));
    assign w_sum_calc   = sat_add(r_sum, TIME_BITS'(w_tmo));
    assign w_stop_calc  = w_remain_pos ? sat_add(r_sum, TIME_BITS'(w_rmt)) : r_sum;
    assign w_fout_calc  = sat_add(r_stop, TIME_BITS'(w_neg_fout));

    assign w_time_ext = CMPW'(r_rd_time);
    assign w_bend_ext = CMPW'(r_bend);
    assign w_hit      = r_rd_ok && (w_time_ext < w_bend_ext);

    always_comb begin
        w_ins_en   = 1'b0;
        w_ins_time = r_start;
        w_ins_tag  = '{kind: KIND_START, track: r_track};
        case (r_state)
            S_INS0: begin
                w_ins_en = 1'b1;
            end
            S_INS1: begin
                w_ins_en   = 1'b1;
                w_ins_time = r_stop;
                w_ins_tag  = '{kind: KIND_STOP, track: r_track};
            end
            S_INS2: begin
                w_ins_en  = 1'b1;
                w_ins_tag = '{kind: KIND_FADE_IN, track: r_track};
            end
            S_INS3: begin
                w_ins_en   = 1'b1;
                w_ins_time = r_fout_time;
                w_ins_tag  = '{kind: KIND_FADE_OUT, track: r_track};
            end
            default: begin
                w_ins_en = 1'b0;
            end
        endcase
    end

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        logic                        w_live;
        logic signed [TIME_BITS-1:0] w_prev_time;
        t_ev_tag                     w_prev_tag;
        logic                        w_prev_shift;

        assign w_live = (CW'(g) < r_count);

        if (g == 0) begin : g_head
            assign w_prev_time  = '0;
            assign w_prev_tag   = '0;
            assign w_prev_shift = 1'b0;
        end else begin : g_body
            assign w_prev_time  = w_cell_time[g-1];
            assign w_prev_tag   = w_cell_tag[g-1];
            assign w_prev_shift = w_cell_shift[g-1];
        end

        pes_cell #(
            .TIME_BITS(TIME_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ins_en     (w_ins_en),
            .i_ins_time   (w_ins_time),
            .i_ins_tag    (w_ins_tag),
            .i_live       (w_live),
            .i_prev_time  (w_prev_time),
            .i_prev_tag   (w_prev_tag),
            .i_prev_shift (w_prev_shift),
            .o_time       (w_cell_time[g]),
            .o_tag        (w_cell_tag[g]),
            .o_shift      (w_cell_shift[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rd_idx    <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_transport <= i_has_transport;
                        r_track     <= i_track_id;
                        r_total     <= i_total_samples;
                        r_overlap   <= i_overlap_samples;
                        r_remain    <= i_remaining_samples;
                        r_fin_nz    <= (i_fade_in_samples != 32'd0);
                        r_fout      <= i_fade_out_samples;
                        r_bend      <= i_block_end;
                        r_state     <= (i_opcode == OP_FETCH) ? S_FETCH : S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_res_time  <= '0;
                    r_res_kind  <= '0;
                    r_res_track <= '0;
                    if (!r_transport) begin
                        r_res_status <= ST_NO_TRANSP;
                        r_state      <= S_DONE;
                    end else if (w_full) begin
                        r_res_status <= ST_FULL;
                        r_state      <= S_DONE;
                    end else begin
                        r_res_status <= ST_ADDED;
                        r_start      <= w_start_calc;
                        r_sum        <= w_sum_calc;
                        r_state      <= S_INS0;
                    end
                end
                S_INS0: begin
                    r_stop  <= w_stop_calc;
                    r_count <= r_count + 1'b1;
                    r_state <= S_INS1;
                end
                S_INS1: begin
                    r_fout_time <= w_fout_calc;
                    r_count     <= r_count + 1'b1;
                    if (r_fin_nz) begin
                        r_state <= S_INS2;
                    end else if (r_fout != 32'd0) begin
                        r_state <= S_INS3;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_INS2: begin
                    r_count <= r_count + 1'b1;
                    r_state <= (r_fout != 32'd0) ? S_INS3 : S_DONE;
                end
                S_INS3: begin
                    r_count <= r_count + 1'b1;
                    r_state <= S_DONE;
                end
                S_FETCH: begin
                    r_rd_ok   <= (r_rd_idx < r_count);
                    r_rd_time <= w_cell_time[r_rd_idx[IW-1:0]];
                    r_rd_tag  <= w_cell_tag[r_rd_idx[IW-1:0]];
                    r_state   <= S_FCMP;
                end
                S_FCMP: begin
                    if (w_hit) begin
                        r_res_status <= ST_GIVEN;
                        r_res_time   <= w_time_ext[47:0];
                        r_res_kind   <= r_rd_tag.kind;
                        r_res_track  <= r_rd_tag.track;
                        r_rd_idx     <= r_rd_idx + 1'b1;
                    end else begin
                        r_res_status <= ST_NONE;
                        r_res_time   <= '0;
                        r_res_kind   <= '0;
                        r_res_track  <= '0;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || !i_stall) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_res_status;
                        r_out_time   <= r_res_time;
                        r_out_kind   <= r_res_kind;
                        r_out_track  <= r_res_track;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_event_time  = r_out_time;
    assign o_event_kind  = r_out_kind;
    assign o_event_track = r_out_track;

`ifndef SYNTHESIS
    a_rd_within_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_idx <= r_count)
        else $error("Read pointer passed the entry count.");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("Entry count exceeds the table depth.");

    a_insert_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ins_en |-> (r_count < CW'(TABLE_DEPTH)))
        else $error("Insert into a full table.");

    a_plain_status_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ST_GIVEN)) |->
            ((o_event_time == 48'sd0) && (o_event_kind == 2'd0) && (o_event_track == 8'd0)))
        else $error("Result without an event carries nonzero event fields.");
`endif

endmodule

/* sv/pes_cell.sv */
// ----------------------------------------------------------------------------
// Playlist event scheduler table cell
// Holds one event of the sorted table and shifts toward higher slots on insert.
// ----------------------------------------------------------------------------
module pes_cell #(
    parameter int TIME_BITS = 48
) (
    input  logic                        i_clk,
    input  logic                        i_ins_en,
    input  logic signed [TIME_BITS-1:0] i_ins_time,
    input  pes_pkg::t_ev_tag            i_ins_tag,
    input  logic                        i_live,
    input  logic signed [TIME_BITS-1:0] i_prev_time,
    input  pes_pkg::t_ev_tag            i_prev_tag,
    input  logic                        i_prev_shift,
    output logic signed [TIME_BITS-1:0] o_time,
    output pes_pkg::t_ev_tag            o_tag,
    output logic                        o_shift
);
    import pes_pkg::*;

    logic signed [TIME_BITS-1:0] r_time;
    logic signed [TIME_BITS-1:0] n_time;
    t_ev_tag                     r_tag;
    t_ev_tag                     n_tag;
    logic                        w_shift;

    // An empty slot counts as later than any new event, so equal times stay in order.
    assign w_shift = !i_live || (r_time > i_ins_time);

    always_comb begin
        n_time = r_time;
        n_tag  = r_tag;
        if (i_ins_en && w_shift) begin
            if (i_prev_shift) begin
                n_time = i_prev_time;
                n_tag  = i_prev_tag;
            end else begin
                n_time = i_ins_time;
                n_tag  = i_ins_tag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_time <= n_time;
        r_tag  <= n_tag;
    end

    assign o_time  = r_time;
    assign o_tag   = r_tag;
    assign o_shift = w_shift;

endmodule

/* sim/tb_playlist_event_scheduler_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Playlist event scheduler testbench
// Sends add and fetch items with random gaps while the result side stalls at
// random. A time-sorted event table kept here gives the expected status and
// event of every item, and each result is checked field by field in order.
// ----------------------------------------------------------------------------
module tb_playlist_event_scheduler_top;
    import pes_pkg::*;

    localparam int          CLK_HALF     = 2;
    localparam int          DEPTH        = 64;
    localparam int          MAX_WAIT     = 16;
    localparam int          IDLE_LIMIT   = 2000;
    localparam int          RANDOM_ITEMS = 380;
    localparam int          SETTLE       = 20;
    localparam longint      TIME_MAX     = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint      TIME_MIN     = -TIME_MAX - 1;
    localparam logic [47:0] BEND_MAX     = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] BEND_MIN     = 48'h8000_0000_0000;

    typedef struct packed {
        logic        opcode;
        logic        transport;
        logic [7:0]  track;
        logic [31:0] total;
        logic [31:0] overlap;
        logic [32:0] remain;
        logic [31:0] fade_in;
        logic [31:0] fade_exit;
        logic [47:0] block_end;
    } sched_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [47:0] ev_time;
        logic [1:0]  kind;
        logic [7:0]  track;
    } sched_result_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic               i_opcode;
    logic               i_has_transport;
    logic [7:0]         i_track_id;
    logic [31:0]        i_total_samples;
    logic [31:0]        i_overlap_samples;
    logic signed [32:0] i_remaining_samples;
    logic [31:0]        i_fade_in_samples;
    logic [31:0]        i_fade_out_samples;
    logic signed [47:0] i_block_end;
    logic               o_valid;
    logic               i_stall;
    logic [2:0]         o_status;
    logic signed [47:0] o_event_time;
    logic [1:0]         o_event_kind;
    logic [7:0]         o_event_track;

    longint        tbl_time  [DEPTH];
    logic [1:0]    tbl_kind  [DEPTH];
    logic [7:0]    tbl_track [DEPTH];
    int            tbl_count      = 0;
    int            tbl_rd         = 0;
    longint        sample_sum     = 0;
    sched_result_t pending_results[$];

    int mismatches     = 0;
    int n_sent         = 0;
    int n_added        = 0;
    int n_no_transport = 0;
    int n_full         = 0;
    int n_given        = 0;
    int n_none         = 0;
    int idle_cycles    = 0;
    bit idle_on        = 1'b1;

    playlist_event_scheduler_top u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_opcode            (i_opcode),
        .i_has_transport     (i_has_transport),
        .i_track_id          (i_track_id),
        .i_total_samples     (i_total_samples),
        .i_overlap_samples   (i_overlap_samples),
        .i_remaining_samples (i_remaining_samples),
        .i_fade_in_samples   (i_fade_in_samples),
        .i_fade_out_samples  (i_fade_out_samples),
        .i_block_end         (i_block_end),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_status            (o_status),
        .o_event_time        (o_event_time),
        .o_event_kind        (o_event_kind),
        .o_event_track       (o_event_track)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    function automatic longint clamp_time(longint v);
        if (v > TIME_MAX) return TIME_MAX;
        if (v < TIME_MIN) return TIME_MIN;
        return v;
    endfunction

    function automatic void insert_event(longint t, logic [1:0] kind, logic [7:0] track);
        int pos;
        pos = tbl_count;
        if (pos >= DEPTH) return;
        while (pos > 0 && tbl_time[pos - 1] > t) begin
            tbl_time[pos]  = tbl_time[pos - 1];
            tbl_kind[pos]  = tbl_kind[pos - 1];
            tbl_track[pos] = tbl_track[pos - 1];
            pos--;
        end
        tbl_time[pos]  = t;
        tbl_kind[pos]  = kind;
        tbl_track[pos] = track;
        tbl_count++;
    endfunction

    function automatic sched_result_t schedule_item(sched_item_t it);
        sched_result_t r;
        longint        total;
        longint        overlap;
        longint        remain;
        longint        fin;
        longint        fout;
        longint        start;
        longint        stop;
        longint        bend;
        longint        head;
        int            n_ev;
        r = '0;
        if (it.opcode == OP_ADD) begin
            total   = {32'd0, it.total};
            overlap = {32'd0, it.overlap};
            remain  = {{31{it.remain[32]}}, it.remain};
            fin     = {32'd0, it.fade_in};
            fout    = {32'd0, it.fade_exit};
            if (!it.transport) begin
                r.status = ST_NO_TRANSP;
                return r;
            end
            n_ev = 2;
            if (fin != 0) n_ev++;
            if (fout != 0) n_ev++;
            if (tbl_count + n_ev > DEPTH) begin
                r.status = ST_FULL;
                return r;
            end
            start      = (sample_sum <= 0) ? 64'sd0 : clamp_time(sample_sum - overlap);
            sample_sum = clamp_time(sample_sum + total - overlap);
            stop       = (remain > 0) ? clamp_time(sample_sum + remain - total) : sample_sum;
            insert_event(start, KIND_START, it.track);
            insert_event(stop, KIND_STOP, it.track);
            if (fin != 0) insert_event(start, KIND_FADE_IN, it.track);
            if (fout != 0) insert_event(clamp_time(stop - fout), KIND_FADE_OUT, it.track);
            r.status = ST_ADDED;
        end else begin
            bend = {{16{it.block_end[47]}}, it.block_end};
            if (tbl_rd >= tbl_count || tbl_time[tbl_rd] >= bend) begin
                r.status = ST_NONE;
            end else begin
                head      = tbl_time[tbl_rd];
                r.status  = ST_GIVEN;
                r.ev_time = head[47:0];
                r.kind    = tbl_kind[tbl_rd];
                r.track   = tbl_track[tbl_rd];
                tbl_rd++;
            end
        end
        return r;
    endfunction

    function automatic sched_item_t noise_item();
        sched_item_t it;
        logic [63:0] w;
        w            = {$urandom(), $urandom()};
        it.opcode    = w[0];
        it.transport = w[1];
        it.track     = w[15:8];
        it.total     = $urandom();
        it.overlap   = $urandom();
        it.fade_in   = $urandom();
        it.fade_exit = $urandom();
        w            = {$urandom(), $urandom()};
        it.remain    = w[32:0];
        w            = {$urandom(), $urandom()};
        it.block_end = w[47:0];
        return it;
    endfunction

    function automatic sched_item_t add_item(logic [7:0] track, logic [31:0] total,
                                             logic [31:0] overlap, logic [32:0] remain,
                                             logic [31:0] fin, logic [31:0] fout);
        sched_item_t it;
        it           = noise_item();
        it.opcode    = OP_ADD;
        it.transport = 1'b1;
        it.track     = track;
        it.total     = total;
        it.overlap   = overlap;
        it.remain    = remain;
        it.fade_in   = fin;
        it.fade_exit = fout;
        return it;
    endfunction

    function automatic sched_item_t fetch_item(logic [47:0] bend);
        sched_item_t it;
        it           = noise_item();
        it.opcode    = OP_FETCH;
        it.block_end = bend;
        return it;
    endfunction

    function automatic logic [31:0] pick_len(bit zero_ok);
        int r;
        r = $urandom_range(0, 9);
        if (zero_ok && r < 4) return 32'd0;
        if (r == 9) return $urandom();
        return $urandom_range(1, 3000);
    endfunction

    function automatic logic [32:0] pick_remain();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        case ($urandom_range(0, 3))
            0:       return 33'd0;
            1:       return {1'b1, w[31:0]};
            2:       return 33'($urandom_range(1, 3000));
            default: return w[32:0];
        endcase
    endfunction

    function automatic sched_item_t rand_add();
        sched_item_t it;
        logic [31:0] overlap;
        case ($urandom_range(0, 3))
            0:       overlap = 32'd0;
            1:       overlap = $urandom();
            default: overlap = $urandom_range(1, 1000);
        endcase
        it = add_item(8'($urandom_range(0, 255)), pick_len(1'b1), overlap, pick_remain(),
                      pick_len(1'b1), pick_len(1'b1));
        it.transport = ($urandom_range(0, 9) != 0);
        return it;
    endfunction

    function automatic sched_item_t sized_add(int n_events);
        logic [31:0] fin;
        logic [31:0] fout;
        fin  = (n_events >= 3) ? pick_len(1'b0) : 32'd0;
        fout = (n_events == 4) ? pick_len(1'b0) : 32'd0;
        return add_item(8'($urandom_range(0, 255)), pick_len(1'b1), $urandom_range(0, 500),
                        pick_remain(), fin, fout);
    endfunction

    function automatic logic [47:0] pick_block_end();
        longint      head;
        longint      offset;
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        if (tbl_rd >= tbl_count || $urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 2))
                0:       return w[47:0];
                1:       return BEND_MIN;
                default: return BEND_MAX;
            endcase
        end
        case ($urandom_range(0, 5))
            0:       offset = -1;
            1:       offset = 0;
            5:       offset = $urandom_range(2, 100000);
            default: offset = 1;
        endcase
        head = clamp_time(tbl_time[tbl_rd] + offset);
        return head[47:0];
    endfunction

    task automatic send_item(input sched_item_t it);
        int            gap;
        sched_result_t r;
        gap = idle_on ? $urandom_range(0, MAX_WAIT) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid             <= 1'b1;
        i_opcode            <= it.opcode;
        i_has_transport     <= it.transport;
        i_track_id          <= it.track;
        i_total_samples     <= it.total;
        i_overlap_samples   <= it.overlap;
        i_remaining_samples <= it.remain;
        i_fade_in_samples   <= it.fade_in;
        i_fade_out_samples  <= it.fade_exit;
        i_block_end         <= it.block_end;
        do @(posedge i_clk); while (o_stall);
        r = schedule_item(it);
        pending_results = {pending_results, r};
        n_sent++;
        case (r.status)
            ST_ADDED:     n_added++;
            ST_NO_TRANSP: n_no_transport++;
            ST_FULL:      n_full++;
            ST_GIVEN:     n_given++;
            default:      n_none++;
        endcase
    endtask

    task automatic wait_results_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic test_empty_and_rejected();
        sched_item_t it;
        send_item(fetch_item(BEND_MAX));
        it = add_item(8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 33'h1_FFFF_FFFF,
                      32'hFFFF_FFFF, 32'hFFFF_FFFF);
        it.transport = 1'b0;
        send_item(it);
    endtask

    task automatic test_time_arithmetic();
        send_item(add_item(8'h01, 32'd1000, 32'd0, 33'd0, 32'd0, 32'd0));
        send_item(add_item(8'h02, 32'd1000, 32'd100, 33'd300, 32'd50, 32'd200));
        send_item(add_item(8'hFF, 32'hFFFF_FFFF, 32'd0, 33'h1_0000_0000,
                           32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_item(add_item(8'h00, 32'd0, 32'hFFFF_FFFF, 33'h0_FFFF_FFFF, 32'd0, 32'd0));
        send_item(add_item(8'h80, 32'd0, 32'hFFFF_FFFF, 33'd1, 32'd0, 32'd0));
        send_item(add_item(8'h7F, 32'd5000, 32'd10, 33'd0, 32'd1, 32'd1));
    endtask

    task automatic test_fetch_window();
        longint head;
        send_item(fetch_item(BEND_MIN));
        head = tbl_time[tbl_rd];
        send_item(fetch_item(head[47:0]));
        head = tbl_time[tbl_rd] + 1;
        send_item(fetch_item(head[47:0]));
        repeat (3) send_item(fetch_item(BEND_MAX));
        // This fade-out lands ahead of entries that were already delivered.
        send_item(add_item(8'hAA, 32'd100, 32'd0, 33'd0, 32'd0, 32'hFFFF_FFFF));
        repeat (2) send_item(fetch_item(BEND_MAX));
        wait_results_drained();
    endtask

    task automatic test_random_mix();
        sched_item_t it;
        int          r;
        int          add_pct;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            idle_on = ((i / 64) % 2) == 0;
            if ($urandom_range(0, 39) == 0) wait_results_drained();
            add_pct = (tbl_count <= DEPTH - 4) ? 20 : 10;
            r = $urandom_range(0, 99);
            if (r < 5) it = noise_item();
            else if (r < add_pct) it = rand_add();
            else it = fetch_item(pick_block_end());
            send_item(it);
        end
        idle_on = 1'b1;
    endtask

    task automatic test_table_full();
        sched_item_t it;
        while (tbl_count <= DEPTH - 2) send_item(sized_add($urandom_range(2, 4)));
        send_item(sized_add(2));
        send_item(sized_add(4));
        it = sized_add(2);
        it.transport = 1'b0;
        send_item(it);
    endtask

    task automatic test_drain_table();
        int left;
        left = tbl_count - tbl_rd;
        repeat (left) send_item(fetch_item(BEND_MAX));
        send_item(fetch_item(BEND_MAX));
    endtask

    task automatic check_result(input sched_result_t got);
        sched_result_t want;
        if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("Unexpected result: status %0d time %0d kind %0d track %0d",
                         got.status, $signed(got.ev_time), got.kind, got.track);
        end else begin
            want = pending_results.pop_front();
            if (got.status !== want.status || got.ev_time !== want.ev_time ||
                got.kind !== want.kind || got.track !== want.track) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Mismatch: expected status %0d time %0d kind %0d track %0d, %s",
                             want.status, $signed(want.ev_time), want.kind, want.track,
                             $sformatf("got status %0d time %0d kind %0d track %0d",
                                       got.status, $signed(got.ev_time), got.kind,
                                       got.track));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            check_result({o_status, o_event_time, o_event_kind, o_event_track});
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout after %0d cycles without a handshake.", idle_cycles);
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : result_sink
        int hold;
        i_stall <= 1'b0;
        @(posedge i_clk);
        forever begin
            hold = idle_on ? $urandom_range(0, MAX_WAIT) : 0;
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
                i_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!(i_rst_n && o_valid === 1'b1 && !i_stall));
        end
    end

    initial begin
        i_rst_n             <= 1'b0;
        i_valid             <= 1'b0;
        i_opcode            <= OP_ADD;
        i_has_transport     <= 1'b0;
        i_track_id          <= '0;
        i_total_samples     <= '0;
        i_overlap_samples   <= '0;
        i_remaining_samples <= '0;
        i_fade_in_samples   <= '0;
        i_fade_out_samples  <= '0;
        i_block_end         <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_and_rejected();
        test_time_arithmetic();
        test_fetch_window();
        test_random_mix();
        test_table_full();
        test_drain_table();
        wait_results_drained();
        repeat (SETTLE) @(posedge i_clk);
        $display("Summary: %0d items, %0d tracks added, %0d without transport, %0d refused full.",
                 n_sent, n_added, n_no_transport, n_full);
        $display("Summary: %0d events delivered, %0d fetches with nothing due, %0d mismatches.",
                 n_given, n_none, mismatches);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
